// File: rtl/core/caf_pkg.sv
// ----------------------------------------------------------------------------
// caf_pkg
// Types, constants and the corner-mask decoder for the cell area fraction block.
// ----------------------------------------------------------------------------
`default_nettype none

package caf_pkg;

    localparam int DIST_WIDTH  = 24;
    localparam int FRAC_BITS   = 30;
    localparam int DIV_STAGES  = FRAC_BITS;
    localparam int QUEUE_DEPTH = 2;
    localparam int AREA_WIDTH  = 17;
    localparam logic [AREA_WIDTH-1:0] ONE_Q16 = AREA_WIDTH'(65536);

    typedef logic signed [DIST_WIDTH-1:0] dist_t;

    typedef struct packed {
        dist_t dist_lower_left;
        dist_t dist_upper_left;
        dist_t dist_lower_right;
        dist_t dist_upper_right;
    } corners_t;

    typedef struct packed {
        logic [AREA_WIDTH-1:0] area_fraction;
        logic [3:0]            corner_mask;
    } result_t;

    typedef enum logic [2:0] {
        CASE_NONE,
        CASE_ALL,
        CASE_ONE,
        CASE_THREE,
        CASE_OPP,
        CASE_ADJ
    } case_t;

    typedef struct packed {
        case_t      kind;
        logic [1:0] corner;
    } cls_t;

    // Edge e runs from ring corner e to corner e+1. mag/span are taken from
    // the reference end of the edge; zero/full flag the trivial fractions.
    typedef struct packed {
        case_t                       kind;
        logic [1:0]                  corner;
        logic [3:0]                  mask;
        logic [3:0][DIST_WIDTH-1:0]  mag;
        logic [3:0][DIST_WIDTH-1:0]  span;
        logic [3:0]                  zero;
        logic [3:0]                  full;
    } job_t;

    // Ring order: 0 lower-left, 1 upper-left, 2 upper-right, 3 lower-right.
    function automatic cls_t classify(input logic [3:0] mask);
        cls_t c;
        c.corner = 2'd0;
        unique case (mask)
            4'h0: c.kind = CASE_NONE;
            4'hF: c.kind = CASE_ALL;
            4'h1: c.kind = CASE_ONE;
            4'h2: begin c.kind = CASE_ONE; c.corner = 2'd1; end
            4'h4: begin c.kind = CASE_ONE; c.corner = 2'd2; end
            4'h8: begin c.kind = CASE_ONE; c.corner = 2'd3; end
            4'hE: c.kind = CASE_THREE;
            4'hD: begin c.kind = CASE_THREE; c.corner = 2'd1; end
            4'hB: begin c.kind = CASE_THREE; c.corner = 2'd2; end
            4'h7: begin c.kind = CASE_THREE; c.corner = 2'd3; end
            4'h5: c.kind = CASE_OPP;
            4'hA: begin c.kind = CASE_OPP; c.corner = 2'd1; end
            4'h3: c.kind = CASE_ADJ;
            4'h6: begin c.kind = CASE_ADJ; c.corner = 2'd1; end
            4'hC: begin c.kind = CASE_ADJ; c.corner = 2'd2; end
            4'h9: begin c.kind = CASE_ADJ; c.corner = 2'd3; end
            default: c.kind = CASE_NONE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/caf_front.sv
// ----------------------------------------------------------------------------
// caf_front
// Accepts corner items, builds the inside mask and case, and sets up the
// edge divisions, one per cell edge (magnitude, span, trivial flags).
// ----------------------------------------------------------------------------
`default_nettype none

module caf_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               corners_valid,
    output logic                    corners_ready,
    input  wire caf_pkg::corners_t  corners,
    output logic                    job_valid,
    input  wire logic               job_ready,
    output caf_pkg::job_t           job
);
    import caf_pkg::*;

    localparam int EW = DIST_WIDTH + 2;

    dist_t                 d [4];
    logic [3:0]            mask;
    cls_t                  cls;
    logic signed [EW-1:0]  c_ext [4];
    logic signed [EW-1:0]  n_ext [4];
    logic signed [EW-1:0]  mag_ext [4];
    logic signed [EW-1:0]  span_ext [4];
    job_t                  job_next;
    job_t                  job_reg;
    logic                  valid_reg;

    always_comb
    begin
        d[0] = corners.dist_lower_left;
        d[1] = corners.dist_upper_left;
        d[2] = corners.dist_upper_right;
        d[3] = corners.dist_lower_right;
        for (int e = 0; e < 4; e++)
        begin
            mask[e] = d[e][DIST_WIDTH-1];
        end
        cls = classify(mask);
        job_next.kind   = cls.kind;
        job_next.corner = cls.corner;
        job_next.mask   = mask;
        for (int e = 0; e < 4; e++)
        begin
            // reference end: the lone outside corner in the three-inside case,
            // otherwise the inside corner
            if ((cls.kind == CASE_THREE) ? !mask[e] : mask[e])
            begin
                c_ext[e] = EW'(d[e]);
                n_ext[e] = EW'(d[2'(e + 1)]);
            end
            else
            begin
                c_ext[e] = EW'(d[2'(e + 1)]);
                n_ext[e] = EW'(d[e]);
            end
            if (c_ext[e] < 0)
            begin
                mag_ext[e]  = -c_ext[e];
                span_ext[e] = n_ext[e] - c_ext[e];
            end
            else
            begin
                mag_ext[e]  = c_ext[e];
                span_ext[e] = c_ext[e] - n_ext[e];
            end
            job_next.zero[e] = (span_ext[e] <= 0);
            job_next.full[e] = (span_ext[e] > 0) && (mag_ext[e] >= span_ext[e]);
            job_next.mag[e]  = mag_ext[e][DIST_WIDTH-1:0];
            job_next.span[e] = span_ext[e][DIST_WIDTH-1:0];
        end
    end

    assign corners_ready = !valid_reg || job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (corners_ready)
        begin
            valid_reg <= corners_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (corners_ready && corners_valid)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = valid_reg;
    assign job       = job_reg;

endmodule

`default_nettype wire

// File: rtl/core/caf_queue.sv
// ----------------------------------------------------------------------------
// caf_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module caf_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire caf_pkg::job_t  push_job,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output caf_pkg::job_t       pop_job
);
    import caf_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t            mem [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/caf_back.sv
// ----------------------------------------------------------------------------
// caf_back
// Four-lane pipelined restoring divider (one quotient bit per stage), then
// triangle products, case combine, saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module caf_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  wire caf_pkg::job_t     job,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output caf_pkg::result_t       result
);
    import caf_pkg::*;

    localparam int FW = FRAC_BITS + 1;
    localparam int PRW = 2 * FW;

    typedef struct packed {
        case_t                       kind;
        logic [1:0]                  corner;
        logic [3:0]                  mask;
        logic [3:0][DIST_WIDTH-1:0]  rem;
        logic [3:0][DIST_WIDTH-1:0]  span;
        logic [3:0][FRAC_BITS-1:0]   quo;
        logic [3:0]                  zero;
        logic [3:0]                  full;
    } div_t;

    function automatic div_t div_step(input div_t s);
        div_t                o;
        logic [DIST_WIDTH:0] t;
        o = s;
        for (int e = 0; e < 4; e++)
        begin
            t = {s.rem[e], 1'b0};
            if (t >= {1'b0, s.span[e]})
            begin
                o.rem[e] = DIST_WIDTH'(t - {1'b0, s.span[e]});
                o.quo[e] = {s.quo[e][FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                o.rem[e] = t[DIST_WIDTH-1:0];
                o.quo[e] = {s.quo[e][FRAC_BITS-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    logic                  en;
    div_t                  load;
    div_t                  stg_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_reg;

    logic [FW-1:0]         f [4];
    logic [1:0]            ka, kb, kc, kd;
    logic                  mul_valid_reg;
    case_t                 mul_kind_reg;
    logic [3:0]            mul_mask_reg;
    logic [PRW-1:0]        prod_a_reg;
    logic [PRW-1:0]        prod_b_reg;
    logic [FW:0]           adj_sum_reg;

    logic [PRW-1:0]        rnd_a;
    logic [PRW-1:0]        rnd_b;
    logic [FW:0]           rnd_s;
    logic [AREA_WIDTH:0]   area;
    logic                  out_valid_reg;
    result_t               result_reg;
    result_t               result_next;

    assign en        = !out_valid_reg || result_ready;
    assign job_ready = en;

    always_comb
    begin
        load.kind   = job.kind;
        load.corner = job.corner;
        load.mask   = job.mask;
        load.rem    = job.mag;
        load.span   = job.span;
        load.quo    = '0;
        load.zero   = job.zero;
        load.full   = job.full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[DIV_STAGES-2:0], job_valid};
            mul_valid_reg <= vld_reg[DIV_STAGES-1];
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg[0] <= div_step(load);
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                stg_reg[s] <= div_step(stg_reg[s-1]);
            end
        end
    end

    // Edge fractions in Q1.30; triangle at corner k uses edges k and k-1.
    always_comb
    begin
        for (int e = 0; e < 4; e++)
        begin
            if (stg_reg[DIV_STAGES-1].zero[e])
            begin
                f[e] = '0;
            end
            else if (stg_reg[DIV_STAGES-1].full[e])
            begin
                f[e] = FW'(1) << FRAC_BITS;
            end
            else
            begin
                f[e] = {1'b0, stg_reg[DIV_STAGES-1].quo[e]};
            end
        end
        ka = stg_reg[DIV_STAGES-1].corner;
        kb = ka + 2'd3;
        kc = ka + 2'd2;
        kd = ka + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_kind_reg <= stg_reg[DIV_STAGES-1].kind;
            mul_mask_reg <= stg_reg[DIV_STAGES-1].mask;
            prod_a_reg   <= f[ka] * f[kb];
            prod_b_reg   <= f[kc] * f[kd];
            adj_sum_reg  <= {1'b0, f[kb]} + {1'b0, f[kd]};
        end
    end

    always_comb
    begin
        rnd_a = prod_a_reg + (PRW'(1) << 44);
        rnd_b = prod_b_reg + (PRW'(1) << 44);
        rnd_s = adj_sum_reg + ((FW + 1)'(1) << 14);
        case (mul_kind_reg)
            CASE_NONE:  area = '0;
            CASE_ALL:   area = {1'b0, ONE_Q16};
            CASE_ONE:   area = (AREA_WIDTH + 1)'(rnd_a[PRW-1:45]);
            CASE_THREE: area = {1'b0, ONE_Q16} - (AREA_WIDTH + 1)'(rnd_a[PRW-1:45]);
            CASE_OPP:   area = (AREA_WIDTH + 1)'(rnd_a[PRW-1:45])
                               + (AREA_WIDTH + 1)'(rnd_b[PRW-1:45]);
            CASE_ADJ:   area = (AREA_WIDTH + 1)'(rnd_s[FW:15]);
            default:    area = '0;
        endcase
        result_next.area_fraction = (area > {1'b0, ONE_Q16}) ? ONE_Q16
                                                             : area[AREA_WIDTH-1:0];
        result_next.corner_mask   = mul_mask_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// File: rtl/core/cell_area_fraction_top.sv
// ----------------------------------------------------------------------------
// cell_area_fraction_top
// Inside area fraction of one grid cell from its four corner distances.
// ----------------------------------------------------------------------------
// channel   dir  handshake                       payload
// corners   in   corners_valid / corners_ready   caf_pkg::corners_t
// result    out  result_valid / result_ready     caf_pkg::result_t
//
// One item per cycle sustained unless result_ready stalls the back; an item
// passes through the front register (loaded at the accepting edge), the
// queue, 30 divider stages, the product stage and the output register.
// Most of that path is the four-lane divider, one quotient bit per stage.
// Reset clears all valid state; the queue lets the front keep accepting,
// until the queue is full, while the back is stalled by result_ready.
`default_nettype none

module cell_area_fraction_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               corners_valid,
    output logic                    corners_ready,
    input  wire caf_pkg::corners_t  corners,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output caf_pkg::result_t        result
);
    import caf_pkg::*;

    logic  f_valid;
    logic  f_ready;
    job_t  f_job;
    logic  q_valid;
    logic  q_ready;
    job_t  q_job;

    caf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .corners_valid (corners_valid),
        .corners_ready (corners_ready),
        .corners       (corners),
        .job_valid     (f_valid),
        .job_ready     (f_ready),
        .job           (f_job)
    );

    caf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_job    (q_job)
    );

    caf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_valid),
        .job_ready    (q_ready),
        .job          (q_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    a_area_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.area_fraction <= ONE_Q16)
        else $error("area fraction above one");

    a_all_outside: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.corner_mask == 4'h0 |-> result.area_fraction == '0)
        else $error("all-outside cell with nonzero area");

    a_all_inside: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.corner_mask == 4'hF |-> result.area_fraction == ONE_Q16)
        else $error("all-inside cell not full");

    a_three_inside: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && $countones(result.corner_mask) == 3
            |-> result.area_fraction >= 17'd32768)
        else $error("three-inside cell below one half");

endmodule

`default_nettype wire
